[hdl/qrs_pkg.sv]
package qrs_pkg;

    // Coefficient format and the widths that follow from it.
    localparam int CW    = 32;          // coefficient and root part width
    localparam int FB    = 16;          // fraction bits
    localparam int PW    = 2 * CW;      // product of two magnitudes
    localparam int SW    = CW + 1;      // square root of the discriminant
    localparam int SQ_RW = SW + 3;      // square root partial remainder
    localparam int NSW   = SW + 2;      // signed numerator -b +/- s
    localparam int NMW   = SW + 1;      // numerator magnitude
    localparam int QW    = NMW + FB;    // dividend and quotient width
    localparam int DENW  = CW + 1;      // magnitude of 2a

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_A_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] b;
        logic                 a_neg;
        logic                 a_zero;
        logic                 dneg;
        logic [DENW-1:0]      den_mag;
    } sq_side_t;

    typedef struct packed {
        logic [SQ_RW-1:0] rem;
        logic [SW-1:0]    root;
        logic [2*SW-1:0]  rad;
        sq_side_t         side;
    } sq_t;

    typedef struct packed {
        logic            neg_x;
        logic            neg_y;
        logic            neg_m;
        logic            a_zero;
        logic            dneg;
        logic [DENW-1:0] den_mag;
    } dv_side_t;

    typedef struct packed {
        logic [DENW:0] rem_x;
        logic [DENW:0] rem_y;
        logic [QW-1:0] nq_x;
        logic [QW-1:0] nq_y;
        dv_side_t      side;
    } dv_t;

    typedef struct packed {
        logic signed [CW-1:0] value;
        logic                 sat;
    } part_t;

    // Rounds a quotient magnitude to nearest (ties away from zero), applies the
    // sign and saturates to the signed coefficient range.
    function automatic part_t fx_finish(input logic [QW-1:0] q, input logic [DENW:0] rem,
                                        input logic [DENW-1:0] dm, input logic neg);
        logic          up;
        logic [QW:0]   qr;
        logic [QW:0]   lim;
        logic [CW-1:0] mag;
        part_t         res;
        up = (rem >= ({1'b0, dm} - rem));
        qr = {1'b0, q} + (QW+1)'(up);
        if (neg) begin
            lim = (QW+1)'(1) << (CW - 1);
        end else begin
            lim = ((QW+1)'(1) << (CW - 1)) - (QW+1)'(1);
        end
        res.sat = (qr > lim);
        mag = res.sat ? lim[CW-1:0] : qr[CW-1:0];
        res.value = neg ? $signed(-mag) : $signed(mag);
        return res;
    endfunction

endpackage

[hdl/qrs_sqrt_cell.sv]
module qrs_sqrt_cell import qrs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  sq_t  in_data,
    output logic out_valid,
    output sq_t  out_data
);

    logic             valid_reg;
    sq_t              data_reg;
    sq_t              data_next;
    logic [SQ_RW-1:0] rem_sh;
    logic [SQ_RW-1:0] trial;
    logic             ge;

    // One root bit per cell: bring down two radicand bits, try 4r+1.
    always_comb begin
        rem_sh = {in_data.rem[SQ_RW-3:0], in_data.rad[2*SW-1 -: 2]};
        trial  = SQ_RW'({in_data.root, 2'b01});
        ge     = (rem_sh >= trial);
        data_next      = in_data;
        data_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        data_next.root = {in_data.root[SW-2:0], ge};
        data_next.rad  = {in_data.rad[2*SW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/qrs_div_cell.sv]
module qrs_div_cell import qrs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  dv_t  in_data,
    output logic out_valid,
    output dv_t  out_data
);

    logic          valid_reg;
    dv_t           data_reg;
    dv_t           data_next;
    logic [DENW:0] dm;
    logic [DENW:0] sh_x;
    logic [DENW:0] sh_y;
    logic          ge_x;
    logic          ge_y;

    // Two restoring dividers side by side share the divisor. The dividend
    // shifts out at the top while quotient bits shift in at the bottom.
    always_comb begin
        dm   = {1'b0, in_data.side.den_mag};
        sh_x = {in_data.rem_x[DENW-1:0], in_data.nq_x[QW-1]};
        sh_y = {in_data.rem_y[DENW-1:0], in_data.nq_y[QW-1]};
        ge_x = (sh_x >= dm);
        ge_y = (sh_y >= dm);
        data_next       = in_data;
        data_next.rem_x = ge_x ? (sh_x - dm) : sh_x;
        data_next.rem_y = ge_y ? (sh_y - dm) : sh_y;
        data_next.nq_x  = {in_data.nq_x[QW-2:0], ge_x};
        data_next.nq_y  = {in_data.nq_y[QW-2:0], ge_y};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/quadratic_roots_solver.sv]
// Channel  Direction  Beat contents (lowest bits first)
// s_       in         tdata: coef_a, coef_b, coef_c (32 bits each, Q16.16)
// m_       out        tdata: minus_root_real, minus_root_imag, plus_root_real,
//                     plus_root_imag (32 bits each); tuser: solve_status
//
// One coefficient beat is taken per cycle while the output is not stalled on m_tready.
// The pipeline is made of the 33-cell square root row and the 50-cell divider row,
// plus the multiplier, discriminant, numerator and output registers.
// A synchronous active-low reset empties the pipeline; no data is cleared.
// The whole pipeline freezes while a result waits on m_tready.
module quadratic_roots_solver import qrs_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // coef_a, coef_b, coef_c
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // minus_root_real, minus_root_imag, plus_root_real,
                                     // plus_root_imag
    output logic [1:0]    m_tuser    // solve_status
);

    logic adv;

    // Input decode and magnitude products.
    logic signed [CW-1:0] a_in;
    logic signed [CW-1:0] b_in;
    logic signed [CW-1:0] c_in;
    logic [CW-1:0]        a_mag;
    logic [CW-1:0]        b_mag;
    logic [CW-1:0]        c_mag;
    logic [PW-1:0]        bb_prod;
    logic [PW-1:0]        ac_prod;

    logic                 p_valid_reg;
    logic [PW-1:0]        bb_reg;
    logic [PW-1:0]        ac_reg;
    logic signed [CW-1:0] b_reg;
    logic [CW-1:0]        a_mag_reg;
    logic                 a_neg_reg;
    logic                 a_zero_reg;
    logic                 sdiff_reg;

    logic [PW+1:0] ac4;
    logic [PW+1:0] bb_ext;
    logic [PW+1:0] disc;
    logic          dneg;
    sq_t           sq_init;

    logic [SW:0]   sq_vld;
    sq_t           sq_data [SW+1];

    logic signed [NSW-1:0] b_ext;
    logic signed [NSW-1:0] s_ext;
    logic signed [NSW-1:0] num_x;
    logic signed [NSW-1:0] num_y;
    logic [NMW-1:0]        mag_x;
    logic [NMW-1:0]        mag_y;
    dv_t                   dv_init;
    sq_t                   sq_last;

    logic [QW:0]   dv_vld;
    dv_t           dv_data [QW+1];
    dv_t           dv_last;

    part_t part_x;
    part_t part_y;
    part_t part_m;

    logic          out_valid_reg;
    logic [127:0]  out_data_reg;
    logic [127:0]  out_data_next;
    logic [1:0]    out_status_reg;
    logic [1:0]    out_status_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_comb begin
        a_in    = s_tdata[CW-1:0];
        b_in    = s_tdata[2*CW-1:CW];
        c_in    = s_tdata[3*CW-1:2*CW];
        a_mag   = a_in[CW-1] ? (~a_in + 1'b1) : a_in;
        b_mag   = b_in[CW-1] ? (~b_in + 1'b1) : b_in;
        c_mag   = c_in[CW-1] ? (~c_in + 1'b1) : c_in;
        bb_prod = b_mag * b_mag;
        ac_prod = a_mag * c_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bb_reg     <= bb_prod;
            ac_reg     <= ac_prod;
            b_reg      <= b_in;
            a_mag_reg  <= a_mag;
            a_neg_reg  <= a_in[CW-1];
            a_zero_reg <= (a_in == '0);
            sdiff_reg  <= a_in[CW-1] ^ c_in[CW-1];
        end
    end

    // Discriminant magnitude and sign, exact at full width.
    always_comb begin
        ac4    = {ac_reg, 2'b00};
        bb_ext = (PW+2)'(bb_reg);
        dneg   = 1'b0;
        if (sdiff_reg) begin
            disc = bb_ext + ac4;
        end else if (bb_ext >= ac4) begin
            disc = bb_ext - ac4;
        end else begin
            disc = ac4 - bb_ext;
            dneg = 1'b1;
        end
        sq_init.rem          = '0;
        sq_init.root         = '0;
        sq_init.rad          = (2*SW)'(disc);
        sq_init.side.b       = b_reg;
        sq_init.side.a_neg   = a_neg_reg;
        sq_init.side.a_zero  = a_zero_reg;
        sq_init.side.dneg    = dneg;
        sq_init.side.den_mag = {a_mag_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld[0] <= 1'b0;
        end else if (adv) begin
            sq_vld[0] <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_data[0] <= sq_init;
        end
    end

    for (genvar i = 0; i < SW; i++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (sq_vld[i]),
            .in_data   (sq_data[i]),
            .out_valid (sq_vld[i+1]),
            .out_data  (sq_data[i+1])
        );
    end

    // Numerators. For a negative discriminant the real part is -b/(2a) and the
    // second divider works on the root alone.
    always_comb begin
        sq_last = sq_data[SW];
        b_ext   = NSW'(sq_last.side.b);
        s_ext   = $signed({2'b00, sq_last.root});
        if (sq_last.side.dneg) begin
            num_x = -b_ext;
            num_y = s_ext;
        end else begin
            num_x = -b_ext - s_ext;
            num_y = -b_ext + s_ext;
        end
        mag_x = num_x[NSW-1] ? NMW'(-num_x) : NMW'(num_x);
        mag_y = num_y[NSW-1] ? NMW'(-num_y) : NMW'(num_y);
        dv_init.rem_x          = '0;
        dv_init.rem_y          = '0;
        dv_init.nq_x           = {mag_x, {FB{1'b0}}};
        dv_init.nq_y           = {mag_y, {FB{1'b0}}};
        dv_init.side.neg_x     = (num_x != '0) && (num_x[NSW-1] != sq_last.side.a_neg);
        dv_init.side.neg_y     = (num_y != '0) && (num_y[NSW-1] != sq_last.side.a_neg);
        dv_init.side.neg_m     = (sq_last.root != '0) && !sq_last.side.a_neg;
        dv_init.side.a_zero    = sq_last.side.a_zero;
        dv_init.side.dneg      = sq_last.side.dneg;
        dv_init.side.den_mag   = sq_last.side.den_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld[0] <= 1'b0;
        end else if (adv) begin
            dv_vld[0] <= sq_vld[SW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_data[0] <= dv_init;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        qrs_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (dv_vld[j]),
            .in_data   (dv_data[j]),
            .out_valid (dv_vld[j+1]),
            .out_data  (dv_data[j+1])
        );
    end

    // Rounding, sign and saturation of each root part.
    always_comb begin
        dv_last = dv_data[QW];
        part_x  = fx_finish(dv_last.nq_x, dv_last.rem_x, dv_last.side.den_mag,
                            dv_last.side.neg_x);
        part_y  = fx_finish(dv_last.nq_y, dv_last.rem_y, dv_last.side.den_mag,
                            dv_last.side.neg_y);
        part_m  = fx_finish(dv_last.nq_y, dv_last.rem_y, dv_last.side.den_mag,
                            dv_last.side.neg_m);
        if (dv_last.side.a_zero) begin
            out_data_next   = '0;
            out_status_next = ST_A_ZERO;
        end else if (dv_last.side.dneg) begin
            out_data_next   = {part_y.value, part_x.value, part_m.value, part_x.value};
            out_status_next = (part_x.sat || part_y.sat || part_m.sat) ? ST_SAT : ST_OK;
        end else begin
            out_data_next   = {{CW{1'b0}}, part_y.value, {CW{1'b0}}, part_x.value};
            out_status_next = (part_x.sat || part_y.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_vld[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import qrs_pkg::*;

    typedef struct {
        logic [31:0] mrr;
        logic [31:0] mri;
        logic [31:0] prr;
        logic [31:0] pri;
        logic [1:0]  status;
    } roots_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [95:0]   s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [127:0]  m_tdata;
    logic [1:0]    m_tuser;

    roots_t pending_roots[$];
    int     error_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    quadratic_roots_solver DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 aclk = ~aclk;

    // Rounded, saturated (num << 16) / den on signed values.
    function automatic logic [31:0] scaled_quotient(input logic signed [127:0] num,
                                                    input logic signed [127:0] den,
                                                    inout logic sat);
        logic [127:0] nm, dm, q, rem;
        logic         neg;
        nm = num < 0 ? -num : num;
        dm = den < 0 ? -den : den;
        neg = (num != 0) && ((num < 0) != (den < 0));
        q = (nm << 16) / dm;
        rem = (nm << 16) % dm;
        if (rem >= dm - rem) q = q + 1;
        if (neg && q > 128'h8000_0000) begin
            sat = 1'b1;
            q = 128'h8000_0000;
        end else if (!neg && q > 128'h7fff_ffff) begin
            sat = 1'b1;
            q = 128'h7fff_ffff;
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic logic [127:0] wide_isqrt(input logic [127:0] n);
        logic [127:0] r, cand;
        r = 0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            cand = r | (128'd1 << bit_i);
            if (cand * cand <= n) r = cand;
        end
        return r;
    endfunction

    function automatic roots_t solve_roots(input logic [95:0] coefs);
        logic signed [127:0] a, b, c, d, s, den;
        logic         sat;
        roots_t       r;
        a = $signed(coefs[31:0]);
        b = $signed(coefs[63:32]);
        c = $signed(coefs[95:64]);
        sat = 1'b0;
        r = '{default: '0};
        if (a == 0) begin
            r.status = ST_A_ZERO;
            return r;
        end
        d = b * b - 4 * a * c;
        den = 2 * a;
        if (d < 0) begin
            s = wide_isqrt(-d);
            r.mrr = scaled_quotient(-b, den, sat);
            r.prr = r.mrr;
            r.mri = scaled_quotient(-s, den, sat);
            r.pri = scaled_quotient(s, den, sat);
        end else begin
            s = wide_isqrt(d);
            r.mrr = scaled_quotient(-b - s, den, sat);
            r.prr = scaled_quotient(-b + s, den, sat);
        end
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    // Leaves tvalid high after the beat is taken; the next call or the drain
    // step decides whether it drops.
    task automatic send_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        pending_roots.push_back(solve_roots({c, b, a}));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8191)) - 4096) <<< 12;
            2: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(2047)) - 1024) <<< 16;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] ext[6];
        ext = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
        send_coefs(32'h0, 32'h0001_0000, 32'h0002_0000);     // zero a
        send_coefs(32'h0001_0000, 32'h0, 32'hfffc_0000);     // real roots +/-2
        send_coefs(32'h0001_0000, 32'h0, 32'h0004_0000);     // complex roots +/-2i
        send_coefs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000); // double root
        send_coefs(32'h0000_0001, 32'h7fff_ffff, 32'h0);     // saturates
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 3; j++)
                send_coefs(ext[i], ext[(i + j + 1) % 6], ext[(i + 2 * j) % 6]);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_coefs(pick_coef(), pick_coef(), pick_coef());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        roots_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                error_count++;
            end else begin
                exp_r = pending_roots.pop_front();
                if (m_tdata !== {exp_r.pri, exp_r.prr, exp_r.mri, exp_r.mrr}
                    || m_tuser !== exp_r.status) begin
                    $display("%0t: expected %h/%0d, actual %h/%0d", $time,
                             {exp_r.pri, exp_r.prr, exp_r.mri, exp_r.mrr}, exp_r.status,
                             m_tdata, m_tuser);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 12;
        recv_idle_pct = 70;
        test_directed();
        test_random(300);
        send_idle_pct = 70;
        recv_idle_pct = 12;
        test_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(330);
        wait_drained();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/qrs_pkg.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_roots_solver.sv
verif/testbench.sv
